// ===== rtl/core/keypad_multitap_char_entry_defines.svh =====
// Assertion macros shared by the multi-tap keypad entry RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef KEYPAD_MULTITAP_CHAR_ENTRY_DEFINES_SVH
`define KEYPAD_MULTITAP_CHAR_ENTRY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KMT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/kmt_pkg.sv =====
// Shared types, codes and the character table of the multi-tap keypad entry block.
// No dependencies.
package kmt_pkg;

	localparam int KEY_W = 4;
	localparam int POS_W = 4;
	localparam int CHAR_W = 8;
	localparam int CNT_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [KEY_W-1:0] NUM_KEYS = 4'd12;
	localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	localparam logic ACT_PRESS = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONLY_NUM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NO_NL = 2'd2;

	typedef struct packed {
		logic only_numbers;
		logic no_newline;
	} kmt_mode_t;

	// Full, uncut character rows of the keypad.
	function automatic logic [CHAR_W-1:0] kmt_row_char(input logic [KEY_W-1:0] k,
		input logic [POS_W-1:0] p);
		logic [CHAR_W-1:0] c;
		c = 8'h00;
		case (k)
			4'd0: begin
				case (p)
					4'd0: c = 8'h20; 4'd1: c = 8'h08; 4'd2: c = 8'h30;
					4'd3: c = 8'h2B; 4'd4: c = 8'h40; 4'd5: c = 8'h0A;
					default: c = 8'h00;
				endcase
			end
			4'd1: begin
				case (p)
					4'd0: c = 8'h31; 4'd1: c = 8'h2C; 4'd2: c = 8'h2E; 4'd3: c = 8'h3F;
					4'd4: c = 8'h21; 4'd5: c = 8'h28; 4'd6: c = 8'h29;
					default: c = 8'h00;
				endcase
			end
			4'd2: begin
				case (p)
					4'd0: c = 8'h32; 4'd1: c = 8'h41; 4'd2: c = 8'h42; 4'd3: c = 8'h43;
					4'd4: c = 8'h61; 4'd5: c = 8'h62; 4'd6: c = 8'h63;
					default: c = 8'h00;
				endcase
			end
			4'd3: begin
				case (p)
					4'd0: c = 8'h33; 4'd1: c = 8'h44; 4'd2: c = 8'h45; 4'd3: c = 8'h46;
					4'd4: c = 8'h64; 4'd5: c = 8'h65; 4'd6: c = 8'h66;
					default: c = 8'h00;
				endcase
			end
			4'd4: begin
				case (p)
					4'd0: c = 8'h34; 4'd1: c = 8'h47; 4'd2: c = 8'h48; 4'd3: c = 8'h49;
					4'd4: c = 8'h67; 4'd5: c = 8'h68; 4'd6: c = 8'h69;
					default: c = 8'h00;
				endcase
			end
			4'd5: begin
				case (p)
					4'd0: c = 8'h35; 4'd1: c = 8'h4A; 4'd2: c = 8'h4B; 4'd3: c = 8'h4C;
					4'd4: c = 8'h6A; 4'd5: c = 8'h6B; 4'd6: c = 8'h6C;
					default: c = 8'h00;
				endcase
			end
			4'd6: begin
				case (p)
					4'd0: c = 8'h36; 4'd1: c = 8'h4D; 4'd2: c = 8'h4E; 4'd3: c = 8'h4F;
					4'd4: c = 8'h6D; 4'd5: c = 8'h6E; 4'd6: c = 8'h6F;
					default: c = 8'h00;
				endcase
			end
			4'd7: begin
				case (p)
					4'd0: c = 8'h37; 4'd1: c = 8'h50; 4'd2: c = 8'h51; 4'd3: c = 8'h52;
					4'd4: c = 8'h53; 4'd5: c = 8'h70; 4'd6: c = 8'h71; 4'd7: c = 8'h72;
					4'd8: c = 8'h73;
					default: c = 8'h00;
				endcase
			end
			4'd8: begin
				case (p)
					4'd0: c = 8'h38; 4'd1: c = 8'h54; 4'd2: c = 8'h55; 4'd3: c = 8'h56;
					4'd4: c = 8'h74; 4'd5: c = 8'h75; 4'd6: c = 8'h76;
					default: c = 8'h00;
				endcase
			end
			4'd9: begin
				case (p)
					4'd0: c = 8'h39; 4'd1: c = 8'h57; 4'd2: c = 8'h58; 4'd3: c = 8'h59;
					4'd4: c = 8'h5A; 4'd5: c = 8'h77; 4'd6: c = 8'h78; 4'd7: c = 8'h79;
					4'd8: c = 8'h7A;
					default: c = 8'h00;
				endcase
			end
			4'd10: c = (p == 4'd0) ? 8'h2A : 8'h00;
			4'd11: c = (p == 4'd0) ? 8'h23 : 8'h00;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [POS_W-1:0] kmt_full_len(input logic [KEY_W-1:0] k);
		logic [POS_W-1:0] n;
		case (k)
			4'd0: n = 4'd6;
			4'd7, 4'd9: n = 4'd9;
			4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: n = 4'd7;
			4'd10, 4'd11: n = 4'd1;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/core/kmt_row_lookup.sv =====
// Row membership and character at a row position under the current mode.
// Depends on kmt_pkg for the character table and mode type.
module kmt_row_lookup (
	input  logic [kmt_pkg::KEY_W-1:0]  key_sel,
	input  logic [kmt_pkg::POS_W-1:0]  pos_sel,
	input  kmt_pkg::kmt_mode_t         mode,
	output logic                       in_row,
	output logic [kmt_pkg::CHAR_W-1:0] row_char
);
	import kmt_pkg::*;

	logic [POS_W-1:0] row_len;

	always_comb begin
		if (key_sel >= NUM_KEYS) begin
			row_len = '0;
		end else if (key_sel == '0) begin
			if (mode.only_numbers)
				row_len = 4'd2;
			else if (mode.no_newline)
				row_len = 4'd5;
			else
				row_len = kmt_full_len(key_sel);
		end else if (mode.only_numbers) begin
			row_len = 4'd1;
		end else begin
			row_len = kmt_full_len(key_sel);
		end
	end

	assign in_row = (pos_sel < row_len);
	assign row_char = in_row ? kmt_row_char(key_sel, pos_sel) : '0;

endmodule

// ===== rtl/core/keypad_multitap_char_entry.sv =====
// Multi-tap keypad character entry, top level.
// Depends on kmt_pkg, kmt_row_lookup and keypad_multitap_char_entry_defines.svh.
//
// The block takes one request per clock while in_stall is low: a key press (action 0)
// or a one-millisecond tick (action 1), and returns exactly one result per request. A
// request is held in the input register; when it advances, the state update and the
// character lookup land in the result register, which offers the result. The input
// stalls only while the input register holds a request and the result register holds a
// result that is being stalled, so requests can follow back to back.
// Configuration registers (0 timeout_ticks, 1 only_numbers, 2 no_newline) are written
// through cfg_we/cfg_index/cfg_data and should only change while no request is in flight.
`include "keypad_multitap_char_entry_defines.svh"

module keypad_multitap_char_entry (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [kmt_pkg::KEY_W-1:0]      key,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           done_res,
	output logic [kmt_pkg::CHAR_W-1:0]     character,
	output logic                           busy_res,
	output logic [kmt_pkg::KEY_W-1:0]      cursor_key,
	output logic [kmt_pkg::POS_W-1:0]      cursor_pos,
	input  logic                           cfg_we,
	input  logic [kmt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kmt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kmt_pkg::*;

	logic [CNT_W-1:0] timeout_q;
	kmt_mode_t mode_q;

	logic valid_s1;
	logic action_s1;
	logic [KEY_W-1:0] key_s1;

	logic active_q;
	logic [KEY_W-1:0] akey_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;

	logic active_d;
	logic [KEY_W-1:0] akey_d;
	logic [POS_W-1:0] pos_d;
	logic [CNT_W-1:0] cnt_d;
	logic done_d;
	logic [CHAR_W-1:0] char_d;
	logic [CNT_W-1:0] cnt_inc;

	logic out_valid_q;
	logic done_q;
	logic [CHAR_W-1:0] char_q;
	logic busy_q;
	logic [KEY_W-1:0] ckey_q;
	logic [POS_W-1:0] cpos_q;

	logic advance;
	logic in_accept;

	logic in_row;
	logic [CHAR_W-1:0] row_char;

	kmt_row_lookup u_lookup (
		.key_sel  (akey_q),
		.pos_sel  (pos_q),
		.mode     (mode_q),
		.in_row   (in_row),
		.row_char (row_char)
	);

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			mode_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_ONLY_NUM: mode_q.only_numbers <= cfg_data[0];
				REG_NO_NL: mode_q.no_newline <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1 <= action;
			key_s1 <= key;
		end
	end

	assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		active_d = active_q;
		akey_d = akey_q;
		pos_d = pos_q;
		cnt_d = cnt_q;
		done_d = 1'b0;
		char_d = '0;
		if (action_s1 == ACT_PRESS) begin
			if (key_s1 < NUM_KEYS) begin
				if (!active_q) begin
					active_d = 1'b1;
					akey_d = key_s1;
					pos_d = '0;
					cnt_d = '0;
				end else if (key_s1 == akey_q) begin
					pos_d = in_row ? pos_q + 1'b1 : '0;
					cnt_d = '0;
				end
			end
		end else if (active_q) begin
			cnt_d = cnt_inc;
			if (cnt_inc >= timeout_q) begin
				done_d = 1'b1;
				char_d = row_char;
				active_d = 1'b0;
				akey_d = '0;
				pos_d = '0;
				cnt_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			akey_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			active_q <= active_d;
			akey_q <= akey_d;
			pos_q <= pos_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q <= done_d;
			char_q <= char_d;
			busy_q <= active_d;
			ckey_q <= active_d ? akey_d : '0;
			cpos_q <= active_d ? pos_d : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign done_res = done_q;
	assign character = char_q;
	assign busy_res = busy_q;
	assign cursor_key = ckey_q;
	assign cursor_pos = cpos_q;

	`KMT_ASSERT_NOW(a_done_ends_entry, out_valid && done_res, !busy_res, "commit left entry busy")
	`KMT_ASSERT_NOW(a_idle_cursor_zero, out_valid && !busy_res,
		(cursor_key == '0) && (cursor_pos == '0), "idle result carries a cursor")
	`KMT_ASSERT_NOW(a_char_only_on_done, out_valid && !done_res, character == '0,
		"character without commit")
	`KMT_ASSERT_NOW(a_active_key_known, active_q, (akey_q < NUM_KEYS) && (pos_q <= 4'd9),
		"entry state out of range")
	`KMT_ASSERT_NEXT(a_result_follows, advance, out_valid, "processed request lost its result")

endmodule

// ===== bench/kmt_entry_check_pkg.sv =====
// Scoreboard for the multi-tap keypad entry block: predicts each result and checks it.
// Depends on kmt_pkg for widths, key count, register indexes and the reset timeout.
`timescale 1ns / 1ps

package kmt_entry_check_pkg;
	import kmt_pkg::*;

	typedef struct packed {
		logic              done;
		logic [CHAR_W-1:0] ch;
		logic              busy;
		logic [KEY_W-1:0]  ckey;
		logic [POS_W-1:0]  cpos;
	} entry_result_t;

	class char_entry_scoreboard;
		int errors;
		logic [CNT_W-1:0] timeout_ticks;
		logic only_numbers;
		logic no_newline;
		logic entry_on;
		logic [KEY_W-1:0] held_key;
		logic [POS_W-1:0] row_pos;
		logic [CNT_W-1:0] idle_ticks;
		entry_result_t expected_q[$];
		string glyphs[12];

		function new();
			errors = 0;
			timeout_ticks = TIMEOUT_RESET;
			only_numbers = 1'b0;
			no_newline = 1'b0;
			entry_on = 1'b0;
			held_key = '0;
			row_pos = '0;
			idle_ticks = '0;
			glyphs = '{" \0100+@\n", "1,.?!()", "2ABCabc", "3DEFdef", "4GHIghi", "5JKLjkl",
				"6MNOmno", "7PQRSpqrs", "8TUVtuv", "9WXYZwxyz", "*", "#"};
		endfunction

		function int unsigned row_len(logic [KEY_W-1:0] k);
			if (k == 0) begin
				return only_numbers ? 2 : (no_newline ? 5 : 6);
			end
			if (only_numbers) begin
				return 1;
			end
			return glyphs[k].len();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TIMEOUT: timeout_ticks = data;
				REG_ONLY_NUM: only_numbers = data[0];
				REG_NO_NL: no_newline = data[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(logic act, logic [KEY_W-1:0] k);
			entry_result_t r;
			int unsigned len;
			r = '0;
			if (act == ACT_PRESS) begin
				if (k < NUM_KEYS) begin
					if (!entry_on) begin
						entry_on = 1'b1;
						held_key = k;
						row_pos = '0;
						idle_ticks = '0;
					end else if (k == held_key) begin
						len = row_len(held_key);
						if (row_pos < len) row_pos = row_pos + 1'b1;
						else row_pos = '0;
						idle_ticks = '0;
					end
				end
			end else if (entry_on) begin
				if (idle_ticks != CNT_MAX) idle_ticks = idle_ticks + 1'b1;
				if (idle_ticks >= timeout_ticks) begin
					len = row_len(held_key);
					r.done = 1'b1;
					if (row_pos < len) r.ch = glyphs[held_key][row_pos];
					entry_on = 1'b0;
					held_key = '0;
					row_pos = '0;
					idle_ticks = '0;
				end
			end
			r.busy = entry_on;
			r.ckey = entry_on ? held_key : '0;
			r.cpos = entry_on ? row_pos : '0;
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
			if (got !== want) begin
				$error("%s expected %0d got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic done, logic [CHAR_W-1:0] ch, logic busy,
			logic [KEY_W-1:0] ckey, logic [POS_W-1:0] cpos);
			entry_result_t want;
			if (expected_q.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("done_res", CHAR_W'(want.done), CHAR_W'(done));
			compare_field("character", want.ch, ch);
			compare_field("busy_res", CHAR_W'(want.busy), CHAR_W'(busy));
			compare_field("cursor_key", CHAR_W'(want.ckey), CHAR_W'(ckey));
			compare_field("cursor_pos", CHAR_W'(want.cpos), CHAR_W'(cpos));
		endfunction
	endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for keypad_multitap_char_entry: directed and random key/tick requests
// under random sender gaps and receiver stalls. Depends on kmt_pkg and kmt_entry_check_pkg.
`timescale 1ns / 1ps

module tb_top;
	import kmt_pkg::*;
	import kmt_entry_check_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic action;
	logic [KEY_W-1:0] key;
	logic out_valid;
	logic out_stall = 1'b0;
	logic done_res;
	logic [CHAR_W-1:0] character;
	logic busy_res;
	logic [KEY_W-1:0] cursor_key;
	logic [POS_W-1:0] cursor_pos;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	char_entry_scoreboard sb = new();

	logic req_take = 1'b0;
	logic res_take = 1'b0;
	logic req_act;
	logic [KEY_W-1:0] req_key;
	logic s_done;
	logic [CHAR_W-1:0] s_char;
	logic s_busy;
	logic [KEY_W-1:0] s_ckey;
	logic [POS_W-1:0] s_cpos;

	int burst_left = 0;
	int items_sent = 0;
	int cur_timeout = 1000;
	int stall_mode = 0;
	int stall_left = 0;

	keypad_multitap_char_entry dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.key(key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.done_res(done_res),
		.character(character),
		.busy_res(busy_res),
		.cursor_key(cursor_key),
		.cursor_pos(cursor_pos),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Handshakes are sampled mid-cycle, where every signal is settled, and acted on at the
	// following rising edge.
	always @(negedge clk) begin
		req_take = arst_n && in_valid && !in_stall;
		req_act = action;
		req_key = key;
		res_take = arst_n && out_valid && !out_stall;
		s_done = done_res;
		s_char = character;
		s_busy = busy_res;
		s_ckey = cursor_key;
		s_cpos = cursor_pos;
	end

	always @(posedge clk) begin
		if (req_take) sb.note_request(req_act, req_key);
		if (res_take) sb.check_result(s_done, s_char, s_busy, s_ckey, s_cpos);
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ~out_stall;
		endcase
	end

	task automatic send_request(input logic act, input logic [KEY_W-1:0] k);
		bit took;
		int gap;
		in_valid <= 1'b1;
		action <= act;
		key <= k;
		do begin
			@(negedge clk);
			took = (in_stall == 1'b0);
			@(posedge clk);
		end while (!took);
		items_sent++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_request(ACT_TICK, KEY_W'($urandom_range(0, 15)));
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic load_config(input logic [CNT_W-1:0] t, input logic only, input logic nonl);
		put_reg(REG_TIMEOUT, t);
		put_reg(REG_ONLY_NUM, CFG_DATA_W'(only));
		put_reg(REG_NO_NL, CFG_DATA_W'(nonl));
		cfg_we <= 1'b0;
		cur_timeout = int'(t);
	endtask

	// One entry: a start press, repeats with a few stray keys, sometimes a partial wait that
	// a further press restarts, and usually enough ticks to commit.
	task automatic random_entry();
		logic [KEY_W-1:0] k;
		int reps;
		int n;
		k = KEY_W'($urandom_range(0, 11));
		send_request(ACT_PRESS, k);
		reps = $urandom_range(0, 10);
		repeat (reps) begin
			if ($urandom_range(0, 5) == 0) send_request(ACT_PRESS, KEY_W'($urandom_range(0, 15)));
			else send_request(ACT_PRESS, k);
		end
		if (cur_timeout > 1 && $urandom_range(0, 3) == 0) begin
			send_ticks($urandom_range(1, cur_timeout - 1));
			send_request(ACT_PRESS, k);
		end
		if ($urandom_range(0, 7) != 0) begin
			n = (cur_timeout == 0) ? 1 : cur_timeout;
			send_ticks(n + $urandom_range(0, 2));
		end
	endtask

	task automatic run_directed();
		// Reset settings: idle tick, unknown key, ignored key, cancel slot, wrap, commit.
		send_request(ACT_TICK, 4'd0);
		send_request(ACT_PRESS, 4'd15);
		send_request(ACT_PRESS, 4'd11);
		send_request(ACT_PRESS, 4'd4);
		send_request(ACT_PRESS, 4'd11);
		send_request(ACT_PRESS, 4'd11);
		send_ticks(1000);
		settle_block();
		// A zero timeout commits on the first tick.
		load_config(16'd0, 1'b0, 1'b0);
		send_request(ACT_PRESS, 4'd0);
		send_request(ACT_TICK, 4'd7);
		send_request(ACT_PRESS, 4'd9);
		send_request(ACT_PRESS, 4'd9);
		send_request(ACT_TICK, 4'd12);
		settle_block();
		load_config(16'd1, 1'b1, 1'b0);
		send_request(ACT_PRESS, 4'd0);
		send_request(ACT_PRESS, 4'd0);
		send_request(ACT_TICK, 4'd0);
		send_request(ACT_PRESS, 4'd7);
		send_request(ACT_PRESS, 4'd7);
		send_request(ACT_PRESS, 4'd7);
		send_request(ACT_TICK, 4'd0);
		settle_block();
		// Reach the cancel slot of the short row, then lengthen the row mid-entry.
		load_config(16'd2, 1'b0, 1'b1);
		repeat (6) send_request(ACT_PRESS, 4'd0);
		settle_block();
		load_config(16'd2, 1'b0, 1'b0);
		send_ticks(2);
		settle_block();
	endtask

	initial begin
		int target;
		logic [CNT_W-1:0] t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_PRESS;
		key = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TIMEOUT;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int ph = 0; ph < 6; ph++) begin
			settle_block();
			case ($urandom_range(0, 4))
				0: t = 16'd0;
				1: t = 16'd1;
				2: t = 16'd2;
				3: t = 16'd3;
				default: t = CNT_W'($urandom_range(4, 12));
			endcase
			load_config(t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			target = items_sent + 130;
			while (items_sent < target) begin
				if ($urandom_range(0, 4) == 0)
					send_request(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 15)));
				else
					random_entry();
			end
		end

		settle_block();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#80_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/kmt_pkg.sv
rtl/core/kmt_row_lookup.sv
rtl/core/keypad_multitap_char_entry.sv
bench/kmt_entry_check_pkg.sv
bench/tb_top.sv
